// ===== rtl/core/rtcctd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcctd_pkg
// Shared types, constants and helper functions for the consistent RTC time
// decoder: snapshot and result layouts, status bits, BCD and hour helpers.
// ----------------------------------------------------------------------------
package rtcctd_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned YEAR_W       = 16;
   localparam int unsigned CUR_YEAR_W   = 14;
   localparam int unsigned YEAR_QUOT_W  = 8;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = CUR_YEAR_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTURY_PRESENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIVOT_YEAR      = 2'd1;

   // reset values
   localparam logic [CUR_YEAR_W-1:0]  CUR_YEAR_RESET  = 14'd2018;
   localparam logic [YEAR_QUOT_W-1:0] YEAR_QUOT_RESET = 8'd20;

   // divide by 100 as multiply by reciprocal, exact below 2**14
   localparam int unsigned DIV100_MUL   = 5243;
   localparam int unsigned DIV100_SHIFT = 19;
   localparam int unsigned DIV100_PROD_W = 32;

   // status register b bits
   localparam int unsigned STATUS_BINARY_BIT = 2;
   localparam int unsigned STATUS_H24_BIT    = 1;

   localparam int unsigned PM_BIT   = 7;
   localparam logic [BYTE_W-1:0] HOURS_PER_HALF = 8'd12;
   localparam logic [YEAR_W-1:0] YEARS_PER_CENTURY = 16'd100;

   typedef struct packed {
      logic [BYTE_W-1:0] century;
      logic [BYTE_W-1:0] year;
      logic [BYTE_W-1:0] month;
      logic [BYTE_W-1:0] day;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] minute;
      logic [BYTE_W-1:0] second;
   } snap_type;

   typedef struct packed {
      logic [BYTE_W-1:0] second;
      logic [BYTE_W-1:0] minute;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] day;
      logic [BYTE_W-1:0] month;
      logic [YEAR_W-1:0] full_year;
   } result_type;

   typedef struct packed {
      logic                   century_present;
      logic [CUR_YEAR_W-1:0]  pivot_year;
      logic [YEAR_QUOT_W-1:0] year_quot;
   } cfg_type;

   // low nibble plus ten times high nibble, wrapped to a byte
   function automatic logic [BYTE_W-1:0] bcd_byte(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] tens;
      tens = {4'd0, v[7:4]};
      return 8'({4'd0, v[3:0]} + 8'(tens * 8'd10));
   endfunction

   // remainder by twelve for a 7-bit value
   function automatic logic [6:0] mod12(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (r >= 7'd96) r = r - 7'd96;
      if (r >= 7'd48) r = r - 7'd48;
      if (r >= 7'd24) r = r - 7'd24;
      if (r >= 7'd12) r = r - 7'd12;
      return r;
   endfunction

endpackage

// ===== rtl/core/rtcctd_decode.sv =====
// ----------------------------------------------------------------------------
// rtcctd_decode
// Decodes one raw clock snapshot: BCD to binary unless binary mode is set, 12-hour to 24-hour form
// and the full year from the century byte or the reference year.
// ----------------------------------------------------------------------------
module rtcctd_decode (
   input  rtcctd_pkg::snap_type                     snap,
   input  logic [rtcctd_pkg::BYTE_W-1:0]            status_b,
   input  rtcctd_pkg::cfg_type                      cfg,
   output rtcctd_pkg::result_type                   result
);

   logic                               binary_mode;
   logic                               h24_mode;
   logic [rtcctd_pkg::BYTE_W-1:0]      sec_dec;
   logic [rtcctd_pkg::BYTE_W-1:0]      min_dec;
   logic [rtcctd_pkg::BYTE_W-1:0]      hour_bcd;
   logic [rtcctd_pkg::BYTE_W-1:0]      hour_dec;
   logic [rtcctd_pkg::BYTE_W-1:0]      hour_24;
   logic [rtcctd_pkg::BYTE_W-1:0]      day_dec;
   logic [rtcctd_pkg::BYTE_W-1:0]      mon_dec;
   logic [rtcctd_pkg::BYTE_W-1:0]      year_dec;
   logic [rtcctd_pkg::BYTE_W-1:0]      cen_dec;
   logic [rtcctd_pkg::YEAR_W-1:0]      year_cen;
   logic [rtcctd_pkg::YEAR_W-1:0]      year_win;
   logic [rtcctd_pkg::YEAR_W-1:0]      year_win_adj;

   assign binary_mode = status_b[rtcctd_pkg::STATUS_BINARY_BIT];
   assign h24_mode    = status_b[rtcctd_pkg::STATUS_H24_BIT];

   // hour tens use bits 6..4 only, pm bit kept
   assign hour_bcd = {snap.hour[rtcctd_pkg::PM_BIT],
                      7'({3'd0, snap.hour[3:0]} + 7'(snap.hour[6:4] * 7'd10))};

   assign sec_dec  = binary_mode ? snap.second : rtcctd_pkg::bcd_byte(snap.second);
   assign min_dec  = binary_mode ? snap.minute : rtcctd_pkg::bcd_byte(snap.minute);
   assign hour_dec = binary_mode ? snap.hour   : hour_bcd;
   assign day_dec  = binary_mode ? snap.day    : rtcctd_pkg::bcd_byte(snap.day);
   assign mon_dec  = binary_mode ? snap.month  : rtcctd_pkg::bcd_byte(snap.month);
   assign year_dec = binary_mode ? snap.year   : rtcctd_pkg::bcd_byte(snap.year);
   assign cen_dec  = binary_mode ? snap.century : rtcctd_pkg::bcd_byte(snap.century);

   always_comb begin
      hour_24 = hour_dec;
      if (!h24_mode && hour_dec[rtcctd_pkg::PM_BIT]) begin
         hour_24 = 8'({1'b0, rtcctd_pkg::mod12(hour_dec[6:0])})
                   + rtcctd_pkg::HOURS_PER_HALF;
      end
   end

   assign year_cen = 16'(year_dec) + 16'(16'(cen_dec) * rtcctd_pkg::YEARS_PER_CENTURY);
   assign year_win = 16'(year_dec)
                     + 16'(16'(cfg.year_quot) * rtcctd_pkg::YEARS_PER_CENTURY);

   always_comb begin
      year_win_adj = year_win;
      if (year_win < 16'(cfg.pivot_year)) begin
         year_win_adj = year_win + rtcctd_pkg::YEARS_PER_CENTURY;
      end
   end

   assign result.second    = sec_dec;
   assign result.minute    = min_dec;
   assign result.hour      = hour_24;
   assign result.day       = day_dec;
   assign result.month     = mon_dec;
   assign result.full_year = cfg.century_present ? year_cen : year_win_adj;

endmodule

// ===== rtl/core/rtc_consistent_time_decode.sv =====
// ----------------------------------------------------------------------------
// rtc_consistent_time_decode
// Accepts raw clock snapshots, drops busy ones, and emits the decoded time
// once two non-busy snapshots in a row agree.
// ----------------------------------------------------------------------------
//   channel   ports   direction   content
//   req       req_*   in          busy flag, raw clock bytes, status b
//   rsp       rsp_*   out         decoded time and full year
//   csr       csr_*   in          century_present, pivot year
//
// one snapshot per cycle while req_ready stays high; a snapshot is held in the input
// register and its result is registered in the output register
// while a result waits, snapshots that complete no read still pass through;
// one that completes a read holds the input register and drops req_ready
// synchronous reset clears valid flags and the held-snapshot flag, and resets the csrs
// ----------------------------------------------------------------------------
module rtc_consistent_time_decode (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_update_busy,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_raw_second,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_raw_minute,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_raw_hour,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_raw_day,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_raw_month,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_raw_year,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_raw_century,
   input  logic [rtcctd_pkg::BYTE_W-1:0]           req_status_b,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [rtcctd_pkg::BYTE_W-1:0]           rsp_second,
   output logic [rtcctd_pkg::BYTE_W-1:0]           rsp_minute,
   output logic [rtcctd_pkg::BYTE_W-1:0]           rsp_hour,
   output logic [rtcctd_pkg::BYTE_W-1:0]           rsp_day,
   output logic [rtcctd_pkg::BYTE_W-1:0]           rsp_month,
   output logic [rtcctd_pkg::YEAR_W-1:0]           rsp_full_year,

   input  logic                                    csr_write_en,
   input  logic [rtcctd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rtcctd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic                                  s1_valid_ff, s1_valid_in;
   logic                                  s1_busy_ff;
   rtcctd_pkg::snap_type                  s1_snap_ff;
   logic [rtcctd_pkg::BYTE_W-1:0]         s1_status_ff;

   rtcctd_pkg::snap_type                  prev_snap_ff, prev_snap_in;
   logic                                  have_prev_ff, have_prev_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   rtcctd_pkg::result_type                rsp_data_ff;

   logic                                  century_present_ff, century_present_in;
   logic [rtcctd_pkg::CUR_YEAR_W-1:0]     pivot_year_ff, pivot_year_in;
   logic [rtcctd_pkg::YEAR_QUOT_W-1:0]    year_quot_ff, year_quot_in;
   logic [rtcctd_pkg::DIV100_PROD_W-1:0]  quot_prod;

   rtcctd_pkg::cfg_type                   cfg;
   rtcctd_pkg::result_type                dec_result;

   logic                                  req_xfer;
   logic                                  rsp_xfer;
   logic                                  out_free;
   logic                                  snap_match;
   logic                                  s1_emit;
   logic                                  s1_done;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // compare against held snapshot, century only when present
   assign snap_match = (s1_snap_ff.second == prev_snap_ff.second)
                    && (s1_snap_ff.minute == prev_snap_ff.minute)
                    && (s1_snap_ff.hour   == prev_snap_ff.hour)
                    && (s1_snap_ff.day    == prev_snap_ff.day)
                    && (s1_snap_ff.month  == prev_snap_ff.month)
                    && (s1_snap_ff.year   == prev_snap_ff.year)
                    && (!century_present_ff
                        || (s1_snap_ff.century == prev_snap_ff.century));

   assign s1_emit   = s1_valid_ff && !s1_busy_ff && have_prev_ff && snap_match;
   assign s1_done   = s1_valid_ff && (!s1_emit || out_free);
   assign req_ready = !s1_valid_ff || s1_done;

   always_comb begin
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_done);
      prev_snap_in = prev_snap_ff;
      have_prev_in = have_prev_ff;
      if (s1_done && !s1_busy_ff) begin
         if (s1_emit) begin
            have_prev_in = 1'b0;
         end else begin
            prev_snap_in = s1_snap_ff;
            have_prev_in = 1'b1;
         end
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_xfer) || (s1_done && s1_emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_busy_ff         <= req_update_busy;
         s1_snap_ff.second  <= req_raw_second;
         s1_snap_ff.minute  <= req_raw_minute;
         s1_snap_ff.hour    <= req_raw_hour;
         s1_snap_ff.day     <= req_raw_day;
         s1_snap_ff.month   <= req_raw_month;
         s1_snap_ff.year    <= req_raw_year;
         s1_snap_ff.century <= req_raw_century;
         s1_status_ff       <= req_status_b;
      end
      prev_snap_ff <= prev_snap_in;
      if (s1_done && s1_emit) begin
         rsp_data_ff <= dec_result;
      end
   end

   // csr writes; pivot year / 100 kept alongside for year windowing
   assign quot_prod = rtcctd_pkg::DIV100_PROD_W'(csr_wdata)
                      * rtcctd_pkg::DIV100_PROD_W'(rtcctd_pkg::DIV100_MUL);

   always_comb begin
      century_present_in = century_present_ff;
      pivot_year_in      = pivot_year_ff;
      year_quot_in       = year_quot_ff;
      if (csr_write_en) begin
         case (csr_index)
            rtcctd_pkg::CSR_CENTURY_PRESENT: begin
               century_present_in = csr_wdata[0];
            end
            rtcctd_pkg::CSR_PIVOT_YEAR: begin
               pivot_year_in = csr_wdata;
               year_quot_in  = rtcctd_pkg::YEAR_QUOT_W'(
                                  quot_prod >> rtcctd_pkg::DIV100_SHIFT);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         century_present_ff <= 1'b0;
         pivot_year_ff      <= rtcctd_pkg::CUR_YEAR_RESET;
         year_quot_ff       <= rtcctd_pkg::YEAR_QUOT_RESET;
      end else begin
         century_present_ff <= century_present_in;
         pivot_year_ff      <= pivot_year_in;
         year_quot_ff       <= year_quot_in;
      end
   end

   assign cfg.century_present = century_present_ff;
   assign cfg.pivot_year      = pivot_year_ff;
   assign cfg.year_quot       = year_quot_ff;

   rtcctd_decode u_decode (
      .snap     (s1_snap_ff),
      .status_b (s1_status_ff),
      .cfg      (cfg),
      .result   (dec_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_second    = rsp_data_ff.second;
   assign rsp_minute    = rsp_data_ff.minute;
   assign rsp_hour      = rsp_data_ff.hour;
   assign rsp_day       = rsp_data_ff.day;
   assign rsp_month     = rsp_data_ff.month;
   assign rsp_full_year = rsp_data_ff.full_year;

endmodule

// ===== sim/tb_rtc_consistent_time_decode.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtc_consistent_time_decode
// Drives raw clock snapshots into the decoder with random gaps and output
// stalls. A directed table covers busy drops, BCD and binary extremes, the
// 12-hour conversion and both year forms. Random reads follow under several
// register settings. Each result transfer is checked against a typed-in time
// or a local decoder that tracks the held snapshot and the registers.
// ----------------------------------------------------------------------------
module tb_rtc_consistent_time_decode;

   localparam logic [rtcctd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [rtcctd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned IDLE_PCT    = 34;
   localparam int unsigned PHASE_ITEMS = 253;
   localparam rtcctd_pkg::result_type NO_TIME = '0;

   typedef enum logic {ROW_SNAP, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                          kind;
      logic                                  busy;
      rtcctd_pkg::snap_type                  snap;
      logic [rtcctd_pkg::BYTE_W-1:0]         status;
      bit                                    lit_on;
      rtcctd_pkg::result_type                lit;
      logic [rtcctd_pkg::CSR_INDEX_W-1:0]    idx;
      logic [rtcctd_pkg::CSR_DATA_W-1:0]     data;
   } plan_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic                                  req_update_busy = 1'b0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_raw_second = '0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_raw_minute = '0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_raw_hour = '0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_raw_day = '0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_raw_month = '0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_raw_year = '0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_raw_century = '0;
   logic [rtcctd_pkg::BYTE_W-1:0]         req_status_b = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic [rtcctd_pkg::BYTE_W-1:0]         rsp_second;
   logic [rtcctd_pkg::BYTE_W-1:0]         rsp_minute;
   logic [rtcctd_pkg::BYTE_W-1:0]         rsp_hour;
   logic [rtcctd_pkg::BYTE_W-1:0]         rsp_day;
   logic [rtcctd_pkg::BYTE_W-1:0]         rsp_month;
   logic [rtcctd_pkg::YEAR_W-1:0]         rsp_full_year;
   logic                                  csr_write_en = 1'b0;
   logic [rtcctd_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [rtcctd_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   // typed-in expectation travels with the snapshot that completes a read
   bit                                    req_lit_on = 1'b0;
   rtcctd_pkg::result_type                req_lit = '0;

   logic                                  cfg_century;
   logic [rtcctd_pkg::CUR_YEAR_W-1:0]     cfg_year;
   rtcctd_pkg::snap_type                  held_snap;
   logic                                  held_valid;
   rtcctd_pkg::result_type                time_due_q[$];
   int unsigned                           mismatch_count = 0;
   int unsigned                           cycle_count = 0;
   int unsigned                           sent_items = 0;
   rtcctd_pkg::snap_type                  last_snap = '0;
   bit                                    calm = 1'b0;
   logic                                  phase_century = 1'b0;
   plan_row_type                          plan[$];

   rtc_consistent_time_decode DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_update_busy (req_update_busy),
      .req_raw_second  (req_raw_second),
      .req_raw_minute  (req_raw_minute),
      .req_raw_hour    (req_raw_hour),
      .req_raw_day     (req_raw_day),
      .req_raw_month   (req_raw_month),
      .req_raw_year    (req_raw_year),
      .req_raw_century (req_raw_century),
      .req_status_b    (req_status_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_second      (rsp_second),
      .rsp_minute      (rsp_minute),
      .rsp_hour        (rsp_hour),
      .rsp_day         (rsp_day),
      .rsp_month       (rsp_month),
      .rsp_full_year   (rsp_full_year),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned bcd_val(input logic [rtcctd_pkg::BYTE_W-1:0] v);
      int unsigned lo, hi;
      lo = v[3:0];
      hi = v[7:4];
      return lo + hi * 10;
   endfunction

   function automatic rtcctd_pkg::result_type decode_time(
         input rtcctd_pkg::snap_type s,
         input logic [rtcctd_pkg::BYTE_W-1:0] status,
         input logic cen_on,
         input logic [rtcctd_pkg::CUR_YEAR_W-1:0] ref_year);
      int unsigned sec, min, hr, day, mon, yr, cen, tens, cy, full;
      rtcctd_pkg::result_type r;
      sec = s.second;
      min = s.minute;
      hr  = s.hour;
      day = s.day;
      mon = s.month;
      yr  = s.year;
      cen = s.century;
      if (!status[rtcctd_pkg::STATUS_BINARY_BIT]) begin
         sec  = bcd_val(s.second);
         min  = bcd_val(s.minute);
         tens = s.hour[6:4];
         hr   = s.hour[3:0] + tens * 10 + (s.hour & 8'h80);
         day  = bcd_val(s.day);
         mon  = bcd_val(s.month);
         yr   = bcd_val(s.year);
         cen  = bcd_val(s.century);
      end
      if (!status[rtcctd_pkg::STATUS_H24_BIT] && hr[rtcctd_pkg::PM_BIT])
         hr = (hr & 'h7F) % 12 + 12;
      if (cen_on) begin
         full = yr + cen * 100;
      end else begin
         cy   = ref_year;
         full = yr + (cy / 100) * 100;
         if (full < cy)
            full = full + 100;
      end
      r.second    = sec[7:0];
      r.minute    = min[7:0];
      r.hour      = hr[7:0];
      r.day       = day[7:0];
      r.month     = mon[7:0];
      r.full_year = full[15:0];
      return r;
   endfunction

   // holds or completes a read for the snapshot transferred at this edge, unless it is busy
   task automatic track_snapshot();
      rtcctd_pkg::snap_type cur;
      logic                 same;
      cur.second  = req_raw_second;
      cur.minute  = req_raw_minute;
      cur.hour    = req_raw_hour;
      cur.day     = req_raw_day;
      cur.month   = req_raw_month;
      cur.year    = req_raw_year;
      cur.century = req_raw_century;
      same = cfg_century ? (cur == held_snap) : (cur[47:0] == held_snap[47:0]);
      if (!req_update_busy) begin
         if (held_valid && same) begin
            held_valid = 1'b0;
            time_due_q.push_back(req_lit_on ? req_lit
                                 : decode_time(cur, req_status_b, cfg_century, cfg_year));
         end else begin
            held_snap  = cur;
            held_valid = 1'b1;
         end
      end
   endtask

   task automatic check_time();
      rtcctd_pkg::result_type due;
      if (time_due_q.size() == 0) begin
         $error("result transfer with no decoded time pending");
         mismatch_count++;
      end else begin
         due = time_due_q.pop_front();
         if (rsp_second !== due.second) begin
            $error("second: expected %0d, actual %0d", due.second, rsp_second);
            mismatch_count++;
         end
         if (rsp_minute !== due.minute) begin
            $error("minute: expected %0d, actual %0d", due.minute, rsp_minute);
            mismatch_count++;
         end
         if (rsp_hour !== due.hour) begin
            $error("hour: expected %0d, actual %0d", due.hour, rsp_hour);
            mismatch_count++;
         end
         if (rsp_day !== due.day) begin
            $error("day: expected %0d, actual %0d", due.day, rsp_day);
            mismatch_count++;
         end
         if (rsp_month !== due.month) begin
            $error("month: expected %0d, actual %0d", due.month, rsp_month);
            mismatch_count++;
         end
         if (rsp_full_year !== due.full_year) begin
            $error("full_year: expected %0d, actual %0d", due.full_year, rsp_full_year);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_century = 1'b0;
         cfg_year    = rtcctd_pkg::CUR_YEAR_RESET;
         held_snap   = '0;
         held_valid  = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_time();
         if (req_valid && req_ready)
            track_snapshot();
         if (csr_write_en) begin
            case (csr_index)
               rtcctd_pkg::CSR_CENTURY_PRESENT: cfg_century = csr_wdata[0];
               rtcctd_pkg::CSR_PIVOT_YEAR:      cfg_year = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_snapshot(input logic busy, input rtcctd_pkg::snap_type s,
                                input logic [rtcctd_pkg::BYTE_W-1:0] status,
                                input bit lit_on, input rtcctd_pkg::result_type lit);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_update_busy <= busy;
      req_raw_second  <= s.second;
      req_raw_minute  <= s.minute;
      req_raw_hour    <= s.hour;
      req_raw_day     <= s.day;
      req_raw_month   <= s.month;
      req_raw_year    <= s.year;
      req_raw_century <= s.century;
      req_status_b    <= status;
      req_lit_on      <= lit_on;
      req_lit         <= lit;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      if (!busy) begin
         last_snap = s;
      end
   endtask

   // wait for all decoded times, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (time_due_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rtcctd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rtcctd_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   function automatic logic [rtcctd_pkg::BYTE_W-1:0] to_bcd(input int unsigned n);
      logic [3:0] hi, lo;
      hi = 4'(n / 10);
      lo = 4'(n % 10);
      return {hi, lo};
   endfunction

   function automatic logic [rtcctd_pkg::BYTE_W-1:0] rand_reg_byte();
      if ($urandom_range(9) < 7)
         return to_bcd($urandom_range(99));
      return 8'($urandom);
   endfunction

   function automatic logic [rtcctd_pkg::BYTE_W-1:0] rand_hour_byte();
      logic [rtcctd_pkg::BYTE_W-1:0] h;
      case ($urandom_range(2))
         0: h = to_bcd($urandom_range(23));
         1: begin
            h = to_bcd($urandom_range(1, 12));
            h[rtcctd_pkg::PM_BIT] = 1'($urandom_range(1));
         end
         default: h = 8'($urandom);
      endcase
      return h;
   endfunction

   function automatic rtcctd_pkg::snap_type rand_snap();
      rtcctd_pkg::snap_type s;
      s.second  = rand_reg_byte();
      s.minute  = rand_reg_byte();
      s.hour    = rand_hour_byte();
      s.day     = rand_reg_byte();
      s.month   = rand_reg_byte();
      s.year    = rand_reg_byte();
      s.century = rand_reg_byte();
      return s;
   endfunction

   task automatic read_attempt();
      rtcctd_pkg::snap_type          a, b;
      logic [rtcctd_pkg::BYTE_W-1:0] sa;
      int unsigned                   pick, k, n;
      a    = rand_snap();
      sa   = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 60) begin
         send_snapshot(1'b0, a, sa, 1'b0, NO_TIME);
         n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
         repeat (n) send_snapshot(1'b1, rand_snap(), 8'($urandom), 1'b0, NO_TIME);
         b = a;
         if (!phase_century)
            b.century = 8'($urandom);
         send_snapshot(1'b0, b, $urandom_range(1) ? sa : 8'($urandom), 1'b0, NO_TIME);
      end else if (pick < 78) begin
         // torn read: one byte differs in the second snapshot, the third repeats it
         send_snapshot(1'b0, a, sa, 1'b0, NO_TIME);
         b = a;
         k = $urandom_range(6);
         b[8*k +: 8] = b[8*k +: 8] ^ 8'($urandom_range(1, 255));
         send_snapshot(1'b0, b, 8'($urandom), 1'b0, NO_TIME);
         send_snapshot(1'b0, b, 8'($urandom), 1'b0, NO_TIME);
      end else if (pick < 88) begin
         send_snapshot(1'b1, a, sa, 1'b0, NO_TIME);
      end else begin
         b = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom)};
         send_snapshot(1'($urandom_range(1)), b, sa, 1'b0, NO_TIME);
      end
   endtask

   function automatic rtcctd_pkg::snap_type raw(input logic [7:0] sec, min, hr, day, mon,
                                                yr, cen);
      rtcctd_pkg::snap_type s;
      s.second  = sec;
      s.minute  = min;
      s.hour    = hr;
      s.day     = day;
      s.month   = mon;
      s.year    = yr;
      s.century = cen;
      return s;
   endfunction

   function automatic rtcctd_pkg::result_type tm(input logic [7:0] sec, min, hr, day, mon,
                                                 input logic [15:0] fy);
      rtcctd_pkg::result_type r;
      r.second    = sec;
      r.minute    = min;
      r.hour      = hr;
      r.day       = day;
      r.month     = mon;
      r.full_year = fy;
      return r;
   endfunction

   function automatic plan_row_type snap_row(input logic busy, input rtcctd_pkg::snap_type s,
                                             input logic [7:0] status, input bit lit_on,
                                             input rtcctd_pkg::result_type lit);
      plan_row_type r;
      r.kind   = ROW_SNAP;
      r.busy   = busy;
      r.snap   = s;
      r.status = status;
      r.lit_on = lit_on;
      r.lit    = lit;
      r.idx    = '0;
      r.data   = '0;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [rtcctd_pkg::CSR_INDEX_W-1:0] idx,
                                            input logic [rtcctd_pkg::CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = snap_row(1'b0, '0, '0, 1'b0, NO_TIME);
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   initial begin
      rtcctd_pkg::snap_type              carry;
      logic [rtcctd_pkg::CUR_YEAR_W-1:0] phase_year;
      int unsigned                       target;

      // reset settings: no century, windowed against 2018
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 0, 0), 0, 0, NO_TIME));
      plan.push_back(snap_row(1, raw(8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55),
                              8'h55, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 0, 0), 0, 1, tm(0, 0, 0, 0, 0, 2100)));
      plan.push_back(snap_row(0, raw(8'h99, 8'h99, 8'h23, 8'h99, 8'h99, 8'h99, 8'h99),
                              8'h02, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(8'h99, 8'h99, 8'h23, 8'h99, 8'h99, 8'h99, 8'h99),
                              8'h02, 1, tm(99, 99, 23, 99, 99, 2099)));
      // twelve o'clock pm, then twelve o'clock am
      plan.push_back(snap_row(0, raw(0, 0, 8'h92, 0, 0, 0, 0), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 8'h92, 0, 0, 0, 0), 0, 1, tm(0, 0, 12, 0, 0, 2100)));
      plan.push_back(snap_row(0, raw(0, 0, 8'h12, 0, 0, 0, 0), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 8'h12, 0, 0, 0, 0), 0, 1, tm(0, 0, 12, 0, 0, 2100)));
      // binary 24-hour keeps hour bit 7
      plan.push_back(snap_row(0, raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                              8'h06, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                              8'h06, 1, tm(255, 255, 255, 255, 255, 2255)));
      // bcd nibbles above nine, 12-hour pm
      plan.push_back(snap_row(0, raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                              8'h00, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                              8'h00, 1, tm(165, 165, 13, 165, 165, 2165)));
      // century byte ignored while absent
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 0, 8'h12), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 0, 8'h34), 8'hFB, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(1, 0, 0, 0, 0, 0, 0), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(2, 0, 0, 0, 0, 0, 0), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(2, 0, 0, 0, 0, 0, 0), 8'hF9, 0, NO_TIME));
      // century present, year window at zero, spare indexes do nothing
      plan.push_back(csr_row(rtcctd_pkg::CSR_CENTURY_PRESENT, 14'h3FFF));
      plan.push_back(csr_row(rtcctd_pkg::CSR_PIVOT_YEAR, 14'd0));
      plan.push_back(csr_row(CSR_SPARE_A, 14'h3FFF));
      plan.push_back(csr_row(CSR_SPARE_B, 14'h2AAA));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 0, 8'h19), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 0, 8'h20), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 0, 8'h20), 0, 1, tm(0, 0, 0, 0, 0, 2000)));
      // no century, window at the top of the range
      plan.push_back(csr_row(rtcctd_pkg::CSR_CENTURY_PRESENT, 14'h2AAA));
      plan.push_back(csr_row(rtcctd_pkg::CSR_PIVOT_YEAR, 14'd9999));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 8'h99, 0), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 8'h99, 0), 0, 1, tm(0, 0, 0, 0, 0, 9999)));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 8'h98, 0), 0, 0, NO_TIME));
      plan.push_back(snap_row(0, raw(0, 0, 0, 0, 0, 8'h98, 0), 0, 0, NO_TIME));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            csr_write(plan[i].idx, plan[i].data);
            csr_write_en <= 1'b0;
         end else begin
            send_snapshot(plan[i].busy, plan[i].snap, plan[i].status,
                          plan[i].lit_on, plan[i].lit);
         end
      end

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: phase_year = 14'd0;
            1: phase_year = 14'd9999;
            3: phase_year = 14'd2018;
            default: phase_year = 14'($urandom_range(9999));
         endcase
         phase_century = (p == 5) ? 1'($urandom_range(1)) : 1'(p % 2);
         csr_write(rtcctd_pkg::CSR_CENTURY_PRESENT, {13'($urandom), phase_century});
         csr_write(rtcctd_pkg::CSR_PIVOT_YEAR, phase_year);
         csr_write_en <= 1'b0;
         calm = (p == 3);
         // resend the last non-busy snapshot from before the register change, century random
         carry = last_snap;
         carry.century = 8'($urandom);
         send_snapshot(1'b0, carry, 8'($urandom), 1'b0, NO_TIME);
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target)
            read_attempt();
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && time_due_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
